/* rtl/core/hac_pkg.sv */
// Shared types, register map and constants of the heading alignment controller.
package hac_pkg;

  localparam int YawW    = 16;
  localparam int TargetW = 17;
  localparam int ErrW    = 16;
  localparam int DriveW  = 15;
  localparam int MagW    = 17;
  localparam int TurnW   = 14;
  localparam int TolW    = 15;
  localparam int GainW   = 10;
  localparam int StableW = 8;
  localparam int SampleW = 16;
  localparam int AddrW   = 5;

  // Register indexes (byte address is four times the index).
  typedef enum logic [2:0] {
    REG_TARGET  = 3'd0,
    REG_TOL     = 3'd1,
    REG_GAIN    = 3'd2,
    REG_TURNMIN = 3'd3,
    REG_TURNMAX = 3'd4,
    REG_STABLE  = 3'd5,
    REG_TIMEOUT = 3'd6
  } reg_idx_t;

  localparam logic signed [TargetW-1:0] TargetRst  = '0;
  localparam logic [TolW-1:0]           TolRst     = TolW'(800);
  localparam logic [GainW-1:0]          GainRst    = GainW'(218);
  localparam logic [TurnW-1:0]          TurnMinRst = TurnW'(800);
  localparam logic [TurnW-1:0]          TurnMaxRst = TurnW'(2200);
  localparam logic [StableW-1:0]        StableRst  = StableW'(6);
  localparam logic [SampleW-1:0]        TimeoutRst = SampleW'(400);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_TURN    = 3'd1,
    ST_SETTLE  = 3'd2,
    ST_ALIGNED = 3'd3,
    ST_TIMEOUT = 3'd4
  } status_t;

  typedef struct packed {
    logic signed [TargetW-1:0] heading_goal;
    logic [TolW-1:0]           tolerance;
    logic [GainW-1:0]          gain_q8;
    logic [TurnW-1:0]          turn_min;
    logic [TurnW-1:0]          turn_max;
    logic [StableW-1:0]        stable_needed;
    logic [SampleW-1:0]        timeout_samples;
  } cfg_t;

  // Word leaving the error stage.
  typedef struct packed {
    logic                   op;
    logic signed [ErrW-1:0] err;
  } err_word_t;

  // Word leaving the control stage.
  typedef struct packed {
    status_t                status;
    logic signed [ErrW-1:0] err;
    logic                   drive_on;
    logic                   neg;
    logic [MagW-1:0]        mag;
  } ctrl_word_t;

endpackage

/* rtl/core/hac_cfg_regs.sv */
// APB register file holding the controller configuration.
module hac_cfg_regs
  import hac_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[AddrW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heading_goal    <= TargetRst;
      cfg.tolerance       <= TolRst;
      cfg.gain_q8         <= GainRst;
      cfg.turn_min        <= TurnMinRst;
      cfg.turn_max        <= TurnMaxRst;
      cfg.stable_needed   <= StableRst;
      cfg.timeout_samples <= TimeoutRst;
    end else if (wr_en) begin
      unique case (idx)
        REG_TARGET:  cfg.heading_goal    <= signed'(pwdata[TargetW-1:0]);
        REG_TOL:     cfg.tolerance       <= pwdata[TolW-1:0];
        REG_GAIN:    cfg.gain_q8         <= pwdata[GainW-1:0];
        REG_TURNMIN: cfg.turn_min        <= pwdata[TurnW-1:0];
        REG_TURNMAX: cfg.turn_max        <= pwdata[TurnW-1:0];
        REG_STABLE:  cfg.stable_needed   <= pwdata[StableW-1:0];
        REG_TIMEOUT: cfg.timeout_samples <= pwdata[SampleW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TARGET:  prdata = 32'(cfg.heading_goal);
      REG_TOL:     prdata = 32'(cfg.tolerance);
      REG_GAIN:    prdata = 32'(cfg.gain_q8);
      REG_TURNMIN: prdata = 32'(cfg.turn_min);
      REG_TURNMAX: prdata = 32'(cfg.turn_max);
      REG_STABLE:  prdata = 32'(cfg.stable_needed);
      REG_TIMEOUT: prdata = 32'(cfg.timeout_samples);
      default:     prdata = '0;
    endcase
  end

endmodule

/* rtl/core/hac_err_stage.sv */
// Input register and heading error wrap stage.
module hac_err_stage
  import hac_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_op,
  input  logic signed [YawW-1:0] in_yaw,
  output logic                   out_valid,
  input  logic                   out_ready,
  output err_word_t              out_word
);

  logic                   in_vld;
  logic                   in_op_q;
  logic signed [YawW-1:0] yaw_q;
  logic                   ready2;
  logic signed [17:0]     diff;
  logic signed [17:0]     wrapped;

  assign ready2   = !out_valid || out_ready;
  assign in_ready = !in_vld || ready2;

  // The difference stays within plus or minus 98303, so at most three full
  // turns are taken off or added.
  assign diff = 18'(cfg.heading_goal) - 18'(yaw_q);

  always_comb begin
    if (diff > 18'sd90000) begin
      wrapped = diff - 18'sd108000;
    end else if (diff > 18'sd54000) begin
      wrapped = diff - 18'sd72000;
    end else if (diff > 18'sd18000) begin
      wrapped = diff - 18'sd36000;
    end else if (diff < -18'sd90000) begin
      wrapped = diff + 18'sd108000;
    end else if (diff < -18'sd54000) begin
      wrapped = diff + 18'sd72000;
    end else if (diff < -18'sd18000) begin
      wrapped = diff + 18'sd36000;
    end else begin
      wrapped = diff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) in_vld <= in_valid;
      if (ready2)   out_valid <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_op_q <= in_op;
      yaw_q   <= in_yaw;
    end
    if (ready2 && in_vld) begin
      out_word.op  <= in_op_q;
      out_word.err <= in_op_q ? '0 : wrapped[ErrW-1:0];
    end
  end

endmodule

/* rtl/core/hac_ctrl_stage.sv */
// Run state, stable and sample counters, and the gain multiplier.
module hac_ctrl_stage
  import hac_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  err_word_t  in_word,
  output logic       out_valid,
  input  logic       out_ready,
  output ctrl_word_t out_word
);

  logic               running;
  logic               running_next;
  logic [StableW-1:0] inband_count;
  logic [StableW-1:0] inband_count_next;
  logic [SampleW-1:0] sample_count;
  logic [SampleW-1:0] sample_count_next;
  logic [StableW-1:0] stable_inc;
  logic [SampleW-1:0] sample_inc;
  logic [ErrW-1:0]    abs_err;
  logic               in_band;
  logic [24:0]        prod;
  status_t            status;
  logic               drive_on;
  logic               take;

  assign in_ready   = !out_valid || out_ready;
  assign take       = in_ready && in_valid;
  assign abs_err    = in_word.err[ErrW-1] ? ErrW'(-in_word.err) : in_word.err;
  assign in_band    = abs_err <= {1'b0, cfg.tolerance};
  assign stable_inc = inband_count + 1'b1;
  assign sample_inc = sample_count + 1'b1;
  assign prod       = abs_err[TolW-1:0] * cfg.gain_q8;

  always_comb begin
    running_next      = running;
    inband_count_next = inband_count;
    sample_count_next = sample_count;
    status            = ST_IDLE;
    drive_on          = 1'b0;
    if (in_word.op) begin
      running_next      = 1'b1;
      inband_count_next = '0;
      sample_count_next = '0;
      status            = ST_TURN;
    end else if (!running) begin
      status = ST_IDLE;
    end else if (sample_count >= cfg.timeout_samples) begin
      running_next = 1'b0;
      status       = ST_TIMEOUT;
    end else if (in_band) begin
      inband_count_next = stable_inc;
      sample_count_next = sample_inc;
      if (stable_inc >= cfg.stable_needed) begin
        running_next = 1'b0;
        status       = ST_ALIGNED;
      end else if (sample_inc >= cfg.timeout_samples) begin
        running_next = 1'b0;
        status       = ST_TIMEOUT;
      end else begin
        status = ST_SETTLE;
      end
    end else begin
      inband_count_next = '0;
      sample_count_next = sample_inc;
      if (sample_inc >= cfg.timeout_samples) begin
        running_next = 1'b0;
        status       = ST_TIMEOUT;
      end else begin
        status   = ST_TURN;
        drive_on = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running      <= 1'b0;
      inband_count <= '0;
      sample_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (in_ready) out_valid <= in_valid;
      if (take) begin
        running      <= running_next;
        inband_count <= inband_count_next;
        sample_count <= sample_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_word.status   <= status;
      out_word.err      <= in_word.err;
      out_word.drive_on <= drive_on;
      out_word.neg      <= in_word.err[ErrW-1];
      out_word.mag      <= prod[24:8];
    end
  end

endmodule

/* rtl/core/hac_out_stage.sv */
// Turn command clamp and output register.
module hac_out_stage
  import hac_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  ctrl_word_t in_word,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [55:0] out_data
);

  logic [TurnW-1:0]         mag_clamped;
  logic signed [DriveW-1:0] right;
  logic signed [DriveW-1:0] left;

  assign in_ready = !out_valid || out_ready;

  // Lower bound first; with crossed bounds, below it gives min, else max.
  always_comb begin
    if (in_word.mag < MagW'(cfg.turn_min)) begin
      mag_clamped = cfg.turn_min;
    end else if (in_word.mag > MagW'(cfg.turn_max)) begin
      mag_clamped = cfg.turn_max;
    end else begin
      mag_clamped = in_word.mag[TurnW-1:0];
    end
  end

  always_comb begin
    if (!in_word.drive_on) begin
      right = '0;
    end else if (in_word.neg) begin
      right = -signed'({1'b0, mag_clamped});
    end else begin
      right = signed'({1'b0, mag_clamped});
    end
    left = -right;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= {7'b0, in_word.status, in_word.err, right, left};
    end
  end

endmodule

/* rtl/core/heading_align_controller.sv */
// Top level of the heading alignment controller.
//
// Turn-in-place heading alignment: a word with tuser high starts a run, each
// following yaw word yields one result word with opposed wheel drives, the
// wrapped heading error and a status code. One word is taken every cycle
// unless the output is held off, and every word gives exactly one result; the
// pipeline runs input register, error wrap, control (run state, counters and
// gain multiplier) and output clamp, and each stage holds its word under
// backpressure while the stages ahead of it keep filling. The run counters
// are updated once per word in the control stage. Configuration must be written
// over APB only while no word is in flight; the block does not enforce this.
module heading_align_controller
  import hac_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [15:0]      s_tdata,   // yaw[15:0]
  input  logic             s_tuser,   // op: 0 yaw sample, 1 start run
  output logic             m_tvalid,
  input  logic             m_tready,
  // left_drive[14:0], right_drive[29:15], heading_error[45:30], status[48:46]
  output logic [55:0]      m_tdata,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t       cfg;
  logic       err_valid;
  logic       err_ready;
  err_word_t  err_word;
  logic       ctrl_valid;
  logic       ctrl_ready;
  ctrl_word_t ctrl_word;

  hac_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hac_err_stage u_err (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser),
    .in_yaw    (signed'(s_tdata)),
    .out_valid (err_valid),
    .out_ready (err_ready),
    .out_word  (err_word)
  );

  hac_ctrl_stage u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (err_valid),
    .in_ready  (err_ready),
    .in_word   (err_word),
    .out_valid (ctrl_valid),
    .out_ready (ctrl_ready),
    .out_word  (ctrl_word)
  );

  hac_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (ctrl_valid),
    .in_ready  (ctrl_ready),
    .in_word   (ctrl_word),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

/* tb/sv/heading_align_controller_tb.sv */
// Self-checking testbench for the heading alignment controller.
`timescale 1ns / 100ps

module heading_align_controller_tb;
  import hac_pkg::*;

  localparam int HalfTurn     = 18000;
  localparam int FullTurn     = 36000;
  localparam int HoldCycles   = 200;
  localparam int StallLimit   = 3000;
  localparam int PhaseItems   = 130;
  localparam int RandomPhases = 12;
  localparam logic OpSample   = 1'b0;
  localparam logic OpStart    = 1'b1;

  typedef struct packed {
    logic             op;
    logic [YawW-1:0]  yaw;
  } sensor_word_t;

  // Field order matches m_tdata from the top bit down.
  typedef struct packed {
    logic [2:0]        status;
    logic [ErrW-1:0]   err;
    logic [DriveW-1:0] right;
    logic [DriveW-1:0] left;
  } drive_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [15:0]      s_tdata = '0;   // yaw[15:0]
  logic             s_tuser = 1'b0; // op
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  // left_drive[14:0], right_drive[29:15], heading_error[45:30], status[48:46]
  logic [55:0]      m_tdata;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  heading_align_controller dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Register copy and run state of the predictor.
  logic signed [TargetW-1:0] cfg_target   = TargetRst;
  logic [TolW-1:0]           cfg_tol      = TolRst;
  logic [GainW-1:0]          cfg_gain     = GainRst;
  logic [TurnW-1:0]          cfg_turn_min = TurnMinRst;
  logic [TurnW-1:0]          cfg_turn_max = TurnMaxRst;
  logic [StableW-1:0]        cfg_stable   = StableRst;
  logic [SampleW-1:0]        cfg_timeout  = TimeoutRst;
  logic                      run_active    = 1'b0;
  logic [StableW-1:0]        settle_count  = '0;
  logic [SampleW-1:0]        spent_samples = '0;

  sensor_word_t  yaw_words[$];
  drive_result_t pending_results[$];

  int words_queued = 0;
  int results_seen = 0;
  int mismatches = 0;
  int runs_started = 0;
  int runs_aligned = 0;
  int runs_timed_out = 0;
  int quiet_cycles = 0;
  int hold_ask = 0;
  int hold_served = 0;
  int hold_left = 0;
  logic src_no_idle = 1'b0;
  logic sink_no_idle = 1'b0;
  logic in_taken = 1'b0;
  logic offer;
  sensor_word_t  next_word;
  drive_result_t got_result;
  drive_result_t want_result;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic drive_result_t predict_drive(logic op, logic [YawW-1:0] yaw_bits);
    drive_result_t r;
    logic signed [YawW-1:0] yaw;
    int err_cd;
    int abs_cd;
    int mag;
    int cmd;
    yaw = yaw_bits;
    r = '0;
    r.status = ST_IDLE;
    if (op == OpStart) begin
      run_active = 1'b1;
      settle_count = '0;
      spent_samples = '0;
      r.status = ST_TURN;
      return r;
    end
    err_cd = int'(cfg_target) - int'(yaw);
    while (err_cd > HalfTurn) err_cd -= FullTurn;
    while (err_cd < -HalfTurn) err_cd += FullTurn;
    r.err = ErrW'(err_cd);
    if (!run_active) return r;
    if (spent_samples >= cfg_timeout) begin
      run_active = 1'b0;
      r.status = ST_TIMEOUT;
      return r;
    end
    abs_cd = (err_cd < 0) ? -err_cd : err_cd;
    spent_samples = spent_samples + 1'b1;
    if (abs_cd <= int'(cfg_tol)) begin
      settle_count = settle_count + 1'b1;
      if (settle_count >= cfg_stable) begin
        run_active = 1'b0;
        r.status = ST_ALIGNED;
      end else if (spent_samples >= cfg_timeout) begin
        run_active = 1'b0;
        r.status = ST_TIMEOUT;
      end else begin
        r.status = ST_SETTLE;
      end
      return r;
    end
    settle_count = '0;
    if (spent_samples >= cfg_timeout) begin
      run_active = 1'b0;
      r.status = ST_TIMEOUT;
      return r;
    end
    // The lower bound is tested first; with crossed bounds it wins only below it.
    mag = (abs_cd * int'(cfg_gain)) >>> 8;
    if (mag < int'(cfg_turn_min)) mag = int'(cfg_turn_min);
    else if (mag > int'(cfg_turn_max)) mag = int'(cfg_turn_max);
    cmd = (err_cd > 0) ? mag : -mag;
    r.left = DriveW'(-cmd);
    r.right = DriveW'(cmd);
    r.status = ST_TURN;
    return r;
  endfunction

  task automatic queue_word(logic op, int yaw);
    sensor_word_t w;
    w.op = op;
    w.yaw = YawW'(yaw);
    yaw_words.push_back(w);
    words_queued++;
  endtask

  // Waits until every queued word has produced its result, then lets the
  // pipeline settle before any register is touched.
  task automatic wait_idle();
    while (results_seen != words_queued) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_TARGET:  cfg_target = value[TargetW-1:0];
      REG_TOL:     cfg_tol = value[TolW-1:0];
      REG_GAIN:    cfg_gain = value[GainW-1:0];
      REG_TURNMIN: cfg_turn_min = value[TurnW-1:0];
      REG_TURNMAX: cfg_turn_max = value[TurnW-1:0];
      REG_STABLE:  cfg_stable = value[StableW-1:0];
      REG_TIMEOUT: cfg_timeout = value[SampleW-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Sender: a held word stays on the bus until it is taken.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      offer = (yaw_words.size() != 0) && (src_no_idle || $urandom_range(99) >= 34);
      if (offer) begin
        next_word = yaw_words.pop_front();
        s_tdata <= next_word.yaw;
        s_tuser <= next_word.op;
      end
      s_tvalid <= offer;
    end
  end

  // Receiver, with an occasional long hold-off on request.
  always @(negedge clk) begin
    if (hold_ask != hold_served) begin
      hold_served = hold_ask;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= sink_no_idle || ($urandom_range(99) >= 34);
    end
  end

  always @(posedge clk) begin
    in_taken = !rst && s_tvalid && s_tready;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      got_result = m_tdata[48:0];
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word %h, nothing expected", $time, m_tdata);
      end else begin
        want_result = pending_results.pop_front();
        if (got_result.left != want_result.left || got_result.right != want_result.right ||
            got_result.err != want_result.err || got_result.status != want_result.status) begin
          mismatches++;
          $display("%0t: expected left %0d right %0d error %0d status %0d, got left %0d right %0d error %0d status %0d",
                   $time, $signed(want_result.left), $signed(want_result.right),
                   $signed(want_result.err), want_result.status, $signed(got_result.left),
                   $signed(got_result.right), $signed(got_result.err), got_result.status);
        end
      end
    end
    if (in_taken) begin
      want_result = predict_drive(s_tuser, s_tdata);
      pending_results.push_back(want_result);
      if (s_tuser == OpStart) runs_started++;
      if (want_result.status == ST_ALIGNED) runs_aligned++;
      if (want_result.status == ST_TIMEOUT) runs_timed_out++;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, StallLimit);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    int vals[7];
    int i;
    int p;
    int err_cd;
    int y;
    int jit;
    int n_samples;
    int phase_start;
    repeat (8) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // Samples while idle, with both wrap limits and full-scale yaw.
    queue_word(OpSample, 18000);
    queue_word(OpSample, -18000);
    queue_word(OpSample, -32768);
    queue_word(OpSample, 32767);
    // A run under reset settings: clamp high in both directions, clamp low, then six in-band samples.
    queue_word(OpStart, -1);
    queue_word(OpSample, -10000);
    queue_word(OpSample, 10000);
    queue_word(OpSample, -900);
    queue_word(OpSample, 500);
    queue_word(OpSample, -800);
    queue_word(OpSample, 0);
    queue_word(OpSample, 100);
    queue_word(OpSample, -300);
    queue_word(OpSample, 750);
    queue_word(OpSample, 0);
    wait_idle();
    // With no stable samples required, the first in-band sample aligns.
    write_reg(REG_STABLE, 0);
    queue_word(OpStart, 0);
    queue_word(OpSample, 0);
    wait_idle();
    // A zero budget times out on the first sample.
    write_reg(REG_TIMEOUT, 0);
    queue_word(OpStart, 0);
    queue_word(OpSample, 0);
    wait_idle();
    // The budget runs out on an out-of-band sample.
    write_reg(REG_TIMEOUT, 3);
    write_reg(REG_STABLE, 6);
    queue_word(OpStart, 0);
    queue_word(OpSample, 5000);
    queue_word(OpSample, -5000);
    queue_word(OpSample, 5000);
    wait_idle();
    // The budget is cut below the count already spent while a run is active.
    write_reg(REG_TIMEOUT, 400);
    queue_word(OpStart, 0);
    queue_word(OpSample, 4000);
    queue_word(OpSample, 4000);
    wait_idle();
    write_reg(REG_TIMEOUT, 1);
    queue_word(OpSample, 4000);

    for (p = 0; p < RandomPhases; p++) begin
      wait_idle();
      vals[0] = int'($urandom_range(72000)) - 36000;
      vals[1] = $urandom_range(1) ? $urandom_range(2000) : $urandom_range(18000);
      vals[2] = $urandom_range(1023);
      vals[3] = $urandom_range(3000);
      vals[4] = vals[3] + $urandom_range(10000 - vals[3]);
      vals[5] = ($urandom_range(7) == 0) ? $urandom_range(255, 1) : $urandom_range(10, 1);
      vals[6] = ($urandom_range(7) == 0) ? $urandom_range(5, 1) : $urandom_range(400, 10);
      case (p)
        0: vals = '{-36000, 0, 0, 0, 0, 1, 1};
        1: vals = '{36000, 18000, 1023, 10000, 10000, 255, 65535};
        2: for (i = 0; i < 7; i++) vals[i] = $urandom;
        3: begin
          vals[3] = $urandom_range(10000, 3000);
          vals[4] = $urandom_range(vals[3] - 1);
        end
        default: ;
      endcase
      for (i = 0; i < 7; i++) write_reg(reg_idx_t'(i), vals[i]);
      if (p == 5) hold_ask++;
      src_no_idle = (p == 6);
      sink_no_idle = (p == 6);
      phase_start = words_queued;
      while (words_queued - phase_start < PhaseItems) begin
        // A run whose error shrinks toward the band, with some noise words.
        queue_word(OpStart, $urandom);
        err_cd = ($urandom_range(3) == 0) ? int'($urandom_range(4000)) - 2000
                                          : int'($urandom_range(36000)) - 18000;
        jit = int'(cfg_tol) / 2 + 1;
        if (jit > 2000) jit = 2000;
        n_samples = $urandom_range(24, 4);
        repeat (n_samples) begin
          if ($urandom_range(99) < 8) begin
            queue_word(OpSample, $urandom);
          end else begin
            y = int'(cfg_target) - err_cd;
            while (y > HalfTurn) y -= FullTurn;
            while (y < -HalfTurn) y += FullTurn;
            queue_word(OpSample, y);
          end
          if ($urandom_range(99) < 3) queue_word(OpStart, $urandom);
          err_cd = err_cd * int'($urandom_range(90, 30)) / 100
                   + int'($urandom_range(2 * jit)) - jit;
        end
        repeat ($urandom_range(2)) queue_word(OpSample, $urandom);
      end
    end
    wait_idle();

    $display("Checked %0d result words from %0d input words over %0d register settings.",
             results_seen, words_queued, RandomPhases + 5);
    $display("Runs started %0d, aligned %0d, timed out %0d; output held off once for %0d cycles.",
             runs_started, runs_aligned, runs_timed_out, HoldCycles);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
